>>> hdl/ecst_pkg.sv
// Package: shared types and constants for the endpoint/conversation stats table.
package ecst_pkg;

   localparam int ENDPOINT_SLOTS_DEF     = 64;
   localparam int CONVERSATION_SLOTS_DEF = 64;

   localparam logic [1:0] FUNC_UPDATE  = 2'd0;
   localparam logic [1:0] FUNC_RD_EP   = 2'd1;
   localparam logic [1:0] FUNC_RD_CV   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EP_SCAN,
      ST_EP_WAIT,
      ST_EP_UPD,
      ST_CV_SCAN,
      ST_CV_WAIT,
      ST_CV_UPD,
      ST_RD_WAIT,
      ST_RD_DONE,
      ST_DONE
   } state_type;

   // which endpoint key is being worked on / which conversation key
   typedef struct packed {
      logic scan_start;   // reset scan pointer
      logic scan_step;    // advance scan pointer
      logic ep_side;      // 0 dest, 1 source
      logic cv_rev;       // 1 reverse key search
      logic ep_apply;     // insert-if-needed and count endpoint
      logic cv_apply;     // count conversation (reverse or insert/forward)
      logic rd_issue;     // read request memory access
      logic rsp_load;     // build read response
      logic clear_out;    // clear update result fields
   } cmd_type;

   typedef struct packed {
      logic scan_end;     // pointer reached used count
      logic hit;          // current pointer matches key
   } status_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [15:0] a);
      logic [32:0] s;
      s = {1'b0, v} + {17'd0, a};
      sat_add = s[32] ? '1 : s[31:0];
   endfunction

endpackage

>>> hdl/endpoint_conversation_stats_table.sv
// Top level: endpoint and conversation statistics table.
//  channel  | handshake            | payload
//  request  | start & !busy        | req_func, req_* header fields, req_slot_index
//  response | rsp_strobe one cycle | rsp_entry_valid .. rsp_table_full
// A packet update runs three or four table scans; each scan visits up to its used
// count plus one slots. Scans compare one slot at a time, each after a memory read.
// A read waits for its registered memory read before the response is built.
// Synchronous reset clears counts only, no clearing pass.
// The response is never held; busy stays high until the strobe cycle ends.
module endpoint_conversation_stats_table #(
   parameter int ENDPOINT_SLOTS     = ecst_pkg::ENDPOINT_SLOTS_DEF,
   parameter int CONVERSATION_SLOTS = ecst_pkg::CONVERSATION_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [47:0] req_dest_mac,
   input  logic [47:0] req_source_mac,
   input  logic [31:0] req_dest_ipv4,
   input  logic [31:0] req_source_ipv4,
   input  logic [15:0] req_packet_length,
   input  logic [5:0]  req_slot_index,
   output logic        rsp_strobe,
   output logic        rsp_entry_valid,
   output logic [47:0] rsp_key_mac,
   output logic [47:0] rsp_key_second,
   output logic [31:0] rsp_count_first,
   output logic [31:0] rsp_bytes_first,
   output logic [31:0] rsp_count_second,
   output logic [31:0] rsp_bytes_second,
   output logic [5:0]  rsp_dest_slot,
   output logic [5:0]  rsp_source_slot,
   output logic [5:0]  rsp_conv_slot,
   output logic        rsp_reverse_hit,
   output logic        rsp_table_full
);

   ecst_pkg::cmd_type    cmd;
   ecst_pkg::status_type status;

   ecst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_func),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_strobe)
   );

   ecst_datapath #(
      .ENDPOINT_SLOTS     (ENDPOINT_SLOTS),
      .CONVERSATION_SLOTS (CONVERSATION_SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .load          (start && !busy),
      .func          (req_func),
      .dest_mac      (req_dest_mac),
      .source_mac    (req_source_mac),
      .dest_ipv4     (req_dest_ipv4),
      .source_ipv4   (req_source_ipv4),
      .packet_length (req_packet_length),
      .slot_index    (req_slot_index),
      .cmd           (cmd),
      .status        (status),
      .entry_valid   (rsp_entry_valid),
      .key_mac       (rsp_key_mac),
      .key_second    (rsp_key_second),
      .count_first   (rsp_count_first),
      .bytes_first   (rsp_bytes_first),
      .count_second  (rsp_count_second),
      .bytes_second  (rsp_bytes_second),
      .dest_slot     (rsp_dest_slot),
      .source_slot   (rsp_source_slot),
      .conv_slot     (rsp_conv_slot),
      .reverse_hit   (rsp_reverse_hit),
      .table_full    (rsp_table_full)
   );

endmodule

>>> hdl/ecst_ctrl.sv
// Controller: sequences searches, updates and reads.
module ecst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            func,
   input  ecst_pkg::status_type  status,
   output ecst_pkg::cmd_type     cmd,
   output logic                  busy,
   output logic                  done
);

   ecst_pkg::state_type state_ff, state_in;
   logic side_ff, side_in;
   logic rev_ff, rev_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecst_pkg::ST_IDLE;
         side_ff  <= 1'b0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         rev_ff   <= rev_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      rev_in   = rev_ff;
      cmd      = '0;
      cmd.ep_side = side_ff;
      cmd.cv_rev  = rev_ff;
      busy     = (state_ff != ecst_pkg::ST_IDLE);
      done     = 1'b0;
      unique case (state_ff)
         ecst_pkg::ST_IDLE: begin
            if (start) begin
               if (func == ecst_pkg::FUNC_UPDATE) begin
                  cmd.scan_start = 1'b1;
                  cmd.clear_out  = 1'b1;
                  side_in  = 1'b0;
                  state_in = ecst_pkg::ST_EP_WAIT;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in = ecst_pkg::ST_RD_WAIT;
               end
            end
         end
         // memory read of pointer entry in flight
         ecst_pkg::ST_EP_WAIT: state_in = ecst_pkg::ST_EP_SCAN;
         ecst_pkg::ST_EP_SCAN: begin
            if (status.hit || status.scan_end) begin
               state_in = ecst_pkg::ST_EP_UPD;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = ecst_pkg::ST_EP_WAIT;
            end
         end
         ecst_pkg::ST_EP_UPD: begin
            cmd.ep_apply   = 1'b1;
            cmd.scan_start = 1'b1;
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ecst_pkg::ST_EP_WAIT;
            end else begin
               rev_in   = 1'b1;
               state_in = ecst_pkg::ST_CV_WAIT;
            end
         end
         ecst_pkg::ST_CV_WAIT: state_in = ecst_pkg::ST_CV_SCAN;
         ecst_pkg::ST_CV_SCAN: begin
            if (status.hit) begin
               state_in = ecst_pkg::ST_CV_UPD;
            end else if (status.scan_end) begin
               if (rev_ff) begin
                  cmd.scan_start = 1'b1;
                  rev_in   = 1'b0;
                  state_in = ecst_pkg::ST_CV_WAIT;
               end else begin
                  state_in = ecst_pkg::ST_CV_UPD;
               end
            end else begin
               cmd.scan_step = 1'b1;
               state_in = ecst_pkg::ST_CV_WAIT;
            end
         end
         ecst_pkg::ST_CV_UPD: begin
            cmd.cv_apply = 1'b1;
            state_in = ecst_pkg::ST_DONE;
         end
         ecst_pkg::ST_RD_WAIT: state_in = ecst_pkg::ST_RD_DONE;
         ecst_pkg::ST_RD_DONE: begin
            cmd.rsp_load = 1'b1;
            state_in = ecst_pkg::ST_DONE;
         end
         ecst_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = ecst_pkg::ST_IDLE;
         end
         default: state_in = ecst_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ecst_pkg::ST_IDLE) else $error("done not followed by idle");
   a_apply_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ep_apply && cmd.cv_apply)) else $error("two applies at once");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not go busy");
`endif

endmodule

>>> hdl/ecst_datapath.sv
// Datapath: table memories, scan pointer, key compare, counter updates.
module ecst_datapath #(
   parameter int ENDPOINT_SLOTS     = ecst_pkg::ENDPOINT_SLOTS_DEF,
   parameter int CONVERSATION_SLOTS = ecst_pkg::CONVERSATION_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [1:0]            func,
   input  logic [47:0]           dest_mac,
   input  logic [47:0]           source_mac,
   input  logic [31:0]           dest_ipv4,
   input  logic [31:0]           source_ipv4,
   input  logic [15:0]           packet_length,
   input  logic [5:0]            slot_index,
   input  ecst_pkg::cmd_type     cmd,
   output ecst_pkg::status_type  status,
   output logic                  entry_valid,
   output logic [47:0]           key_mac,
   output logic [47:0]           key_second,
   output logic [31:0]           count_first,
   output logic [31:0]           bytes_first,
   output logic [31:0]           count_second,
   output logic [31:0]           bytes_second,
   output logic [5:0]            dest_slot,
   output logic [5:0]            source_slot,
   output logic [5:0]            conv_slot,
   output logic                  reverse_hit,
   output logic                  table_full
);

   localparam int EW = $clog2(ENDPOINT_SLOTS);
   localparam int CW = $clog2(CONVERSATION_SLOTS);
   localparam int PW = (EW > CW ? EW : CW) + 1;

   logic [47:0] ep_mac [ENDPOINT_SLOTS];
   logic [31:0] ep_ip  [ENDPOINT_SLOTS];
   logic [31:0] ep_rxp [ENDPOINT_SLOTS];
   logic [31:0] ep_rxb [ENDPOINT_SLOTS];
   logic [31:0] ep_txp [ENDPOINT_SLOTS];
   logic [31:0] ep_txb [ENDPOINT_SLOTS];
   logic [47:0] cv_a   [CONVERSATION_SLOTS];
   logic [47:0] cv_b   [CONVERSATION_SLOTS];
   logic [31:0] cv_fp  [CONVERSATION_SLOTS];
   logic [31:0] cv_fb  [CONVERSATION_SLOTS];
   logic [31:0] cv_rp  [CONVERSATION_SLOTS];
   logic [31:0] cv_rb  [CONVERSATION_SLOTS];

   logic [EW:0] ep_used_ff;
   logic [CW:0] cv_used_ff;
   logic [PW-1:0] ptr_ff;

   logic [1:0]  func_ff;
   logic [47:0] dmac_ff, smac_ff;
   logic [31:0] dip_ff, sip_ff;
   logic [15:0] len_ff;
   logic [5:0]  slot_ff;

   // registered memory read data
   logic [47:0] e_mac_q, c_a_q, c_b_q;
   logic [31:0] e_ip_q, e_rxp_q, e_rxb_q, e_txp_q, e_txb_q;
   logic [31:0] c_fp_q, c_fb_q, c_rp_q, c_rb_q;

   logic [EW-1:0] e_raddr;
   logic [CW-1:0] c_raddr;
   logic [PW-1:0] ptr_in;

   // a read parks the pointer on the requested slot
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.scan_start) ptr_in = '0;
      else if (cmd.rd_issue) ptr_in = PW'(slot_index);
      else if (cmd.scan_step) ptr_in = ptr_ff + 1'b1;
   end

   assign e_raddr = ptr_in[EW-1:0];
   assign c_raddr = ptr_in[CW-1:0];

   logic [47:0] e_key_mac, c_key_a, c_key_b;
   logic [31:0] e_key_ip;
   assign e_key_mac = cmd.ep_side ? smac_ff : dmac_ff;
   assign e_key_ip  = cmd.ep_side ? sip_ff  : dip_ff;
   assign c_key_a   = cmd.cv_rev  ? smac_ff : dmac_ff;
   assign c_key_b   = cmd.cv_rev  ? dmac_ff : smac_ff;

   logic ep_end, cv_end, ep_hit, cv_hit, ep_mode;
   assign ep_end = (PW'(ep_used_ff) <= ptr_ff);
   assign cv_end = (PW'(cv_used_ff) <= ptr_ff);
   assign ep_hit = !ep_end && e_mac_q == e_key_mac && e_ip_q == e_key_ip;
   assign cv_hit = !cv_end && c_a_q == c_key_a && c_b_q == c_key_b;
   logic cv_phase_ff;
   assign ep_mode = !cv_phase_ff;
   assign status.scan_end = ep_mode ? ep_end : cv_end;
   assign status.hit      = ep_mode ? ep_hit : cv_hit;

   logic [EW-1:0] ep_slot;
   logic [CW-1:0] cv_slot;
   assign ep_slot = ptr_ff[EW-1:0];
   assign cv_slot = ptr_ff[CW-1:0];

   logic ep_new, ep_full, cv_new, cv_full;
   assign ep_new  = !ep_hit;
   assign ep_full = ep_new && (ep_used_ff >= (EW+1)'(ENDPOINT_SLOTS));
   assign cv_new  = !cv_hit;
   assign cv_full = cv_new && (cv_used_ff >= (CW+1)'(CONVERSATION_SLOTS));

   logic [31:0] rxp_b, rxb_b, txp_b, txb_b, fp_b, fb_b, rp_b, rb_b;
   assign rxp_b = ep_new ? 32'd0 : e_rxp_q;
   assign rxb_b = ep_new ? 32'd0 : e_rxb_q;
   assign txp_b = ep_new ? 32'd0 : e_txp_q;
   assign txb_b = ep_new ? 32'd0 : e_txb_q;
   assign fp_b  = cv_new ? 32'd0 : c_fp_q;
   assign fb_b  = cv_new ? 32'd0 : c_fb_q;
   assign rp_b  = cv_new ? 32'd0 : c_rp_q;
   assign rb_b  = cv_new ? 32'd0 : c_rb_q;

   always_ff @(posedge clock) begin
      e_mac_q <= ep_mac[e_raddr];
      e_ip_q  <= ep_ip[e_raddr];
      e_rxp_q <= ep_rxp[e_raddr];
      e_rxb_q <= ep_rxb[e_raddr];
      e_txp_q <= ep_txp[e_raddr];
      e_txb_q <= ep_txb[e_raddr];
      c_a_q   <= cv_a[c_raddr];
      c_b_q   <= cv_b[c_raddr];
      c_fp_q  <= cv_fp[c_raddr];
      c_fb_q  <= cv_fb[c_raddr];
      c_rp_q  <= cv_rp[c_raddr];
      c_rb_q  <= cv_rb[c_raddr];
      if (cmd.ep_apply && !ep_full) begin
         ep_mac[ep_slot] <= e_key_mac;
         ep_ip[ep_slot]  <= e_key_ip;
         if (!cmd.ep_side) begin
            ep_rxp[ep_slot] <= ecst_pkg::sat_inc(rxp_b);
            ep_rxb[ep_slot] <= ecst_pkg::sat_add(rxb_b, len_ff);
            ep_txp[ep_slot] <= txp_b;
            ep_txb[ep_slot] <= txb_b;
         end else begin
            ep_rxp[ep_slot] <= rxp_b;
            ep_rxb[ep_slot] <= rxb_b;
            ep_txp[ep_slot] <= ecst_pkg::sat_inc(txp_b);
            ep_txb[ep_slot] <= ecst_pkg::sat_add(txb_b, len_ff);
         end
      end
      if (cmd.cv_apply && !cv_full) begin
         cv_a[cv_slot] <= c_key_a;
         cv_b[cv_slot] <= c_key_b;
         if (cmd.cv_rev) begin
            cv_fp[cv_slot] <= fp_b;
            cv_fb[cv_slot] <= fb_b;
            cv_rp[cv_slot] <= ecst_pkg::sat_inc(rp_b);
            cv_rb[cv_slot] <= ecst_pkg::sat_add(rb_b, len_ff);
         end else begin
            cv_fp[cv_slot] <= ecst_pkg::sat_inc(fp_b);
            cv_fb[cv_slot] <= ecst_pkg::sat_add(fb_b, len_ff);
            cv_rp[cv_slot] <= rp_b;
            cv_rb[cv_slot] <= rb_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ep_used_ff  <= '0;
         cv_used_ff  <= '0;
         ptr_ff      <= '0;
         cv_phase_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.ep_apply && ep_new && !ep_full) ep_used_ff <= ep_used_ff + 1'b1;
         if (cmd.cv_apply && cv_new && !cv_full) cv_used_ff <= cv_used_ff + 1'b1;
         if (cmd.ep_apply && cmd.ep_side) cv_phase_ff <= 1'b1;
         else if (cmd.cv_apply || load) cv_phase_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff <= func;
         dmac_ff <= dest_mac;
         smac_ff <= source_mac;
         dip_ff  <= dest_ipv4;
         sip_ff  <= source_ipv4;
         len_ff  <= packet_length;
         slot_ff <= slot_index;
      end
      if (cmd.clear_out || load) begin
         entry_valid  <= 1'b0;
         key_mac      <= '0;
         key_second   <= '0;
         count_first  <= '0;
         bytes_first  <= '0;
         count_second <= '0;
         bytes_second <= '0;
         dest_slot    <= '0;
         source_slot  <= '0;
         conv_slot    <= '0;
         reverse_hit  <= 1'b0;
         table_full   <= 1'b0;
      end
      if (cmd.ep_apply) begin
         if (ep_full) table_full <= 1'b1;
         else if (!cmd.ep_side) dest_slot <= 6'(ep_slot);
         else source_slot <= 6'(ep_slot);
      end
      if (cmd.cv_apply) begin
         if (cv_full) table_full <= 1'b1;
         else begin
            conv_slot   <= 6'(cv_slot);
            reverse_hit <= cmd.cv_rev;
         end
      end
      if (cmd.rsp_load) begin
         if (func_ff == ecst_pkg::FUNC_RD_EP &&
             13'(ep_used_ff) > 13'(slot_ff)) begin
            entry_valid  <= 1'b1;
            key_mac      <= e_mac_q;
            key_second   <= {16'd0, e_ip_q};
            count_first  <= e_rxp_q;
            bytes_first  <= e_rxb_q;
            count_second <= e_txp_q;
            bytes_second <= e_txb_q;
         end else if (func_ff == ecst_pkg::FUNC_RD_CV &&
             13'(cv_used_ff) > 13'(slot_ff)) begin
            entry_valid  <= 1'b1;
            key_mac      <= c_a_q;
            key_second   <= c_b_q;
            count_first  <= c_fp_q;
            bytes_first  <= c_fb_q;
            count_second <= c_rp_q;
            bytes_second <= c_rb_q;
         end
      end
   end

`ifndef SYNTHESIS
   a_ep_bound: assert property (@(posedge clock) disable iff (reset)
      ep_used_ff <= (EW+1)'(ENDPOINT_SLOTS)) else $error("endpoint count overflow");
   a_cv_bound: assert property (@(posedge clock) disable iff (reset)
      cv_used_ff <= (CW+1)'(CONVERSATION_SLOTS)) else $error("conversation count overflow");
   a_ep_grow: assert property (@(posedge clock) disable iff (reset)
      !cmd.ep_apply |=> $stable(ep_used_ff)) else $error("endpoint count moved");
`endif

endmodule

>>> sim/endpoint_conversation_stats_table_tb.sv
// Testbench for the endpoint/conversation stats table: scoreboard class predicts each response.
`timescale 1ns / 1ps

typedef struct packed {
   logic        entry_valid;
   logic [47:0] key_mac;
   logic [47:0] key_second;
   logic [31:0] count_first;
   logic [31:0] bytes_first;
   logic [31:0] count_second;
   logic [31:0] bytes_second;
   logic [5:0]  dest_slot;
   logic [5:0]  source_slot;
   logic [5:0]  conv_slot;
   logic        reverse_hit;
   logic        table_full;
} stats_rsp_type;

class stats_scoreboard;
   localparam int EP_N = 64;
   localparam int CV_N = 64;

   logic [47:0] ep_mac[EP_N];
   logic [31:0] ep_ip[EP_N];
   logic [31:0] ep_rxp[EP_N], ep_rxb[EP_N], ep_txp[EP_N], ep_txb[EP_N];
   int          ep_cnt;
   logic [47:0] cv_a[CV_N], cv_b[CV_N];
   logic [31:0] cv_fp[CV_N], cv_fb[CV_N], cv_rp[CV_N], cv_rb[CV_N];
   int          cv_cnt;

   stats_rsp_type pending[$];
   int errors;
   int checked;
   int updates, reads, fulls, revs;

   function new();
      ep_cnt = 0;
      cv_cnt = 0;
      errors = 0;
      checked = 0;
      updates = 0;
      reads = 0;
      fulls = 0;
      revs = 0;
   endfunction

   function logic [31:0] inc_sat(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   function logic [31:0] add_sat(logic [31:0] v, logic [15:0] a);
      logic [32:0] s;
      s = {1'b0, v} + {17'd0, a};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function int ep_lookup(logic [47:0] mac, logic [31:0] ip);
      for (int i = 0; i < ep_cnt; i++)
         if (ep_mac[i] == mac && ep_ip[i] == ip) return i;
      if (ep_cnt >= EP_N) return -1;
      ep_mac[ep_cnt] = mac;
      ep_ip[ep_cnt] = ip;
      ep_rxp[ep_cnt] = 0;
      ep_rxb[ep_cnt] = 0;
      ep_txp[ep_cnt] = 0;
      ep_txb[ep_cnt] = 0;
      ep_cnt++;
      return ep_cnt - 1;
   endfunction

   function int cv_search(logic [47:0] a, logic [47:0] b);
      for (int i = 0; i < cv_cnt; i++)
         if (cv_a[i] == a && cv_b[i] == b) return i;
      return -1;
   endfunction

   function void note_request(logic [1:0] fn, logic [47:0] dmac, logic [47:0] smac,
                              logic [31:0] dip, logic [31:0] sip, logic [15:0] len,
                              logic [5:0] slot);
      stats_rsp_type r;
      int d, s, c;
      r = '0;
      if (fn == ecst_pkg::FUNC_UPDATE) begin
         updates++;
         d = ep_lookup(dmac, dip);
         if (d < 0) r.table_full = 1;
         else begin
            ep_rxp[d] = inc_sat(ep_rxp[d]);
            ep_rxb[d] = add_sat(ep_rxb[d], len);
            r.dest_slot = d[5:0];
         end
         s = ep_lookup(smac, sip);
         if (s < 0) r.table_full = 1;
         else begin
            ep_txp[s] = inc_sat(ep_txp[s]);
            ep_txb[s] = add_sat(ep_txb[s], len);
            r.source_slot = s[5:0];
         end
         c = cv_search(smac, dmac);
         if (c >= 0) begin
            cv_rp[c] = inc_sat(cv_rp[c]);
            cv_rb[c] = add_sat(cv_rb[c], len);
            r.conv_slot = c[5:0];
            r.reverse_hit = 1;
            revs++;
         end else begin
            c = cv_search(dmac, smac);
            if (c < 0 && cv_cnt < CV_N) begin
               c = cv_cnt;
               cv_cnt++;
               cv_a[c] = dmac;
               cv_b[c] = smac;
               cv_fp[c] = 0;
               cv_fb[c] = 0;
               cv_rp[c] = 0;
               cv_rb[c] = 0;
            end
            if (c < 0) r.table_full = 1;
            else begin
               cv_fp[c] = inc_sat(cv_fp[c]);
               cv_fb[c] = add_sat(cv_fb[c], len);
               r.conv_slot = c[5:0];
            end
         end
         if (r.table_full) fulls++;
      end else if (fn == ecst_pkg::FUNC_RD_EP) begin
         reads++;
         if (slot < ep_cnt) begin
            r.entry_valid = 1;
            r.key_mac = ep_mac[slot];
            r.key_second = {16'd0, ep_ip[slot]};
            r.count_first = ep_rxp[slot];
            r.bytes_first = ep_rxb[slot];
            r.count_second = ep_txp[slot];
            r.bytes_second = ep_txb[slot];
         end
      end else if (fn == ecst_pkg::FUNC_RD_CV) begin
         reads++;
         if (slot < cv_cnt) begin
            r.entry_valid = 1;
            r.key_mac = cv_a[slot];
            r.key_second = cv_b[slot];
            r.count_first = cv_fp[slot];
            r.bytes_first = cv_fb[slot];
            r.count_second = cv_rp[slot];
            r.bytes_second = cv_rb[slot];
         end
      end
      pending.push_back(r);
   endfunction

   function void check_response(stats_rsp_type got);
      stats_rsp_type e;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("response with nothing pending at %0t", $realtime);
         return;
      end
      e = pending.pop_front();
      if (got != e) begin
         errors++;
         if (errors <= 10)
            $display({"beat %0d: exp v%0b %h %h %h %h %h %h s%0d/%0d/%0d r%0b f%0b",
                      " got v%0b %h %h %h %h %h %h s%0d/%0d/%0d r%0b f%0b"}, checked,
                     e.entry_valid, e.key_mac, e.key_second, e.count_first, e.bytes_first,
                     e.count_second, e.bytes_second, e.dest_slot, e.source_slot,
                     e.conv_slot, e.reverse_hit, e.table_full,
                     got.entry_valid, got.key_mac, got.key_second, got.count_first,
                     got.bytes_first, got.count_second, got.bytes_second, got.dest_slot,
                     got.source_slot, got.conv_slot, got.reverse_hit, got.table_full);
      end
   endfunction
endclass

module endpoint_conversation_stats_table_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [47:0] req_dest_mac = '0;
   logic [47:0] req_source_mac = '0;
   logic [31:0] req_dest_ipv4 = '0;
   logic [31:0] req_source_ipv4 = '0;
   logic [15:0] req_packet_length = '0;
   logic [5:0]  req_slot_index = '0;
   logic        rsp_strobe;
   logic        rsp_entry_valid;
   logic [47:0] rsp_key_mac, rsp_key_second;
   logic [31:0] rsp_count_first, rsp_bytes_first, rsp_count_second, rsp_bytes_second;
   logic [5:0]  rsp_dest_slot, rsp_source_slot, rsp_conv_slot;
   logic        rsp_reverse_hit, rsp_table_full;

   stats_scoreboard sb = new();
   int idle_pct = 0;
   int idle_cnt = 0;
   logic [47:0] mac_pool[8];
   logic [31:0] ip_pool[8];

   endpoint_conversation_stats_table dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      stats_rsp_type got;
      if (!reset && rsp_strobe) begin
         got.entry_valid = rsp_entry_valid;
         got.key_mac = rsp_key_mac;
         got.key_second = rsp_key_second;
         got.count_first = rsp_count_first;
         got.bytes_first = rsp_bytes_first;
         got.count_second = rsp_count_second;
         got.bytes_second = rsp_bytes_second;
         got.dest_slot = rsp_dest_slot;
         got.source_slot = rsp_source_slot;
         got.conv_slot = rsp_conv_slot;
         got.reverse_hit = rsp_reverse_hit;
         got.table_full = rsp_table_full;
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses pending", sb.pending.size());
         $display("endpoint_conversation_stats_table: mismatch");
         $finish;
      end
   end

   // start stays high between back-to-back beats; an idle gap drops it
   task automatic send_beat(logic [1:0] fn, logic [47:0] dmac, logic [47:0] smac,
                            logic [31:0] dip, logic [31:0] sip, logic [15:0] len,
                            logic [5:0] slot);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_func <= fn;
      req_dest_mac <= dmac;
      req_source_mac <= smac;
      req_dest_ipv4 <= dip;
      req_source_ipv4 <= sip;
      req_packet_length <= len;
      req_slot_index <= slot;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(fn, dmac, smac, dip, sip, len, slot);
   endtask

   task automatic random_beat();
      logic [1:0] fn;
      int k;
      logic [47:0] dm, sm;
      logic [31:0] di, si;
      logic [15:0] ln;
      k = $urandom_range(99);
      fn = (k < 65) ? ecst_pkg::FUNC_UPDATE : (k < 80) ? ecst_pkg::FUNC_RD_EP :
           (k < 95) ? ecst_pkg::FUNC_RD_CV : ecst_pkg::FUNC_UNUSED;
      dm = mac_pool[$urandom_range(7)];
      sm = mac_pool[$urandom_range(7)];
      di = ip_pool[$urandom_range(7)];
      si = ip_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) dm = 48'({$urandom, $urandom});
      if ($urandom_range(9) == 0) si = $urandom;
      ln = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
      send_beat(fn, dm, sm, di, si, ln, 6'($urandom_range(9) < 7 ? $urandom_range(15)
                                                                 : $urandom_range(63)));
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         mac_pool[i] = 48'({$urandom, $urandom});
         ip_pool[i] = $urandom;
      end
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reads of empty tables, extremes, same key, reverse hit, unused func
      send_beat(ecst_pkg::FUNC_RD_EP, '0, '0, '0, '0, '0, 6'd0);
      send_beat(ecst_pkg::FUNC_RD_CV, '1, '1, '1, '1, '1, 6'd63);
      send_beat(ecst_pkg::FUNC_UPDATE, '0, '1, '0, '1, 16'hFFFF, '1);
      send_beat(ecst_pkg::FUNC_UPDATE, '1, '0, '1, '0, 16'h0000, '0);
      send_beat(ecst_pkg::FUNC_UPDATE, 48'h1234, 48'h1234, 32'h5, 32'h5, 16'h8000, '0);
      send_beat(ecst_pkg::FUNC_UPDATE, 48'h1234, 48'h1234, 32'h5, 32'h5, 16'h0001, '0);
      send_beat(ecst_pkg::FUNC_UNUSED, '1, '1, '1, '1, '1, '1);
      for (int i = 0; i < 4; i++) begin
         send_beat(ecst_pkg::FUNC_RD_EP, '0, '0, '0, '0, '0, i[5:0]);
         send_beat(ecst_pkg::FUNC_RD_CV, '0, '0, '0, '0, '0, i[5:0]);
      end
      send_beat(ecst_pkg::FUNC_RD_EP, '0, '0, '0, '0, '0, 6'd63);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 45 : (ph == 2) ? 0 : 34;
         for (int n = 0; n < 250; n++) random_beat();
      end
      // fill both tables to overflow
      idle_pct = 20;
      for (int n = 0; n < 60; n++)
         send_beat(ecst_pkg::FUNC_UPDATE, 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), $urandom, $urandom, 16'($urandom), '0);
      for (int n = 0; n < 140; n++) random_beat();
      for (int i = 0; i < 64; i++) begin
         send_beat(ecst_pkg::FUNC_RD_EP, '0, '0, '0, '0, '0, i[5:0]);
         send_beat(ecst_pkg::FUNC_RD_CV, '0, '0, '0, '0, '0, i[5:0]);
      end
      start <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d updates (%0d reverse, %0d full), %0d reads; endpoints %0d, convs %0d",
               sb.updates, sb.revs, sb.fulls, sb.reads, sb.ep_cnt, sb.cv_cnt);
      if (sb.errors == 0) $display("endpoint_conversation_stats_table: match");
      else $display("endpoint_conversation_stats_table: mismatch");
      $finish;
   end
endmodule
